// File: design/ptl_pkg.sv
package ptl_pkg;

  localparam int CW   = 21;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 2;
  localparam int MW   = SW - 1;
  localparam int LOW  = (MW + 1) / 2;
  localparam int HIW  = MW - LOW;
  localparam int NW   = MW + CW;
  localparam int QW   = CW + 2;
  localparam int QIW  = $clog2(QW);
  localparam int CMPW = SW + QW;
  localparam int QSW  = QW + 1;
  localparam int RW   = CW + 4;
  localparam int RRW  = 2 * RW + 2;
  localparam int SQW  = RRW / 2;
  localparam int SIW  = $clog2(SQW);
  localparam int TW   = RRW + 2;
  localparam int OW   = CW + 2;
  localparam int LW   = CW + 1;
  localparam int NRW  = QSW + 1;
  localparam int IDXW = 3;

  typedef enum logic [IDXW-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_END_X,
    REG_END_Y,
    REG_END_Z
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][NW-1:0] rem;
    logic [2:0][QW-1:0] quo;
    logic [SW-1:0]      dd;
    logic               dneg;
    logic [2:0]         dsgn;
    logic [2:0][DW-1:0] v;
    logic [SW-1:0]      vv;
    logic               dot_pos;
    logic               degen;
  } div_t;

  typedef struct packed {
    logic [RRW-1:0]     rrem;
    logic [RRW-1:0]     vrem;
    logic [SQW-1:0]     rroot;
    logic [SQW-1:0]     vroot;
    logic [2:0][OW-1:0] nearest;
    logic               dot_pos;
    logic               degen;
  } sqrt_t;

endpackage

// File: design/ptl_if.sv
interface ptl_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [ptl_pkg::CW-1:0]  point_x;
  logic signed [ptl_pkg::CW-1:0]  point_y;
  logic signed [ptl_pkg::CW-1:0]  point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ptl_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [ptl_pkg::OW-1:0]  nearest_x;
  logic signed [ptl_pkg::OW-1:0]  nearest_y;
  logic signed [ptl_pkg::OW-1:0]  nearest_z;
  logic        [ptl_pkg::LW-1:0]  perp_distance;
  logic signed [ptl_pkg::OW-1:0]  signed_length;
  logic                           degenerate;
  modport source (output valid, nearest_x, nearest_y, nearest_z, perp_distance,
                  signed_length, degenerate, input ready);
  modport sink (input valid, nearest_x, nearest_y, nearest_z, perp_distance,
                signed_length, degenerate, output ready);
endinterface

// File: design/ptl_div_cell.sv
module ptl_div_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [ptl_pkg::QIW-1:0] bit_pos,
  input  logic                    vld_in,
  input  ptl_pkg::div_t           din,
  output logic                    vld_out,
  output ptl_pkg::div_t           dout
);
  import ptl_pkg::*;

  logic [CMPW-1:0] divisor;
  div_t            nxt;

  always_comb begin
    divisor = CMPW'(din.dd) << bit_pos;
    nxt = din;
    for (int i = 0; i < 3; i++) begin
      if (CMPW'(din.rem[i]) >= divisor) begin
        nxt.rem[i] = din.rem[i] - NW'(divisor);
        nxt.quo[i][bit_pos] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// File: design/ptl_sqrt_cell.sv
module ptl_sqrt_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [ptl_pkg::SIW-1:0] bit_pos,
  input  logic                    vld_in,
  input  ptl_pkg::sqrt_t          din,
  output logic                    vld_out,
  output ptl_pkg::sqrt_t          dout
);
  import ptl_pkg::*;

  logic [TW-1:0] unit;
  logic [TW-1:0] trial_r;
  logic [TW-1:0] trial_v;
  sqrt_t         nxt;

  always_comb begin
    unit = TW'(1) << {bit_pos, 1'b0};
    trial_r = (TW'(din.rroot) << (bit_pos + 1'b1)) + unit;
    trial_v = (TW'(din.vroot) << (bit_pos + 1'b1)) + unit;
    nxt = din;
    if (TW'(din.rrem) >= trial_r) begin
      nxt.rrem = din.rrem - RRW'(trial_r);
      nxt.rroot[bit_pos] = 1'b1;
    end
    if (TW'(din.vrem) >= trial_v) begin
      nxt.vrem = din.vrem - RRW'(trial_v);
      nxt.vroot[bit_pos] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// File: design/point_to_line_distance_core.sv
// Throughput is one transaction per cycle while the output side is not stalled, set
// by a chain of 23 divider cells and 26 square root cells that each resolve one
// result bit per cycle. Reset clears all valid bits and sets the six line endpoint
// registers to zero.
module point_to_line_distance_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [ptl_pkg::IDXW-1:0] wr_index,
  input  logic [ptl_pkg::CW-1:0] wr_data,
  ptl_in_if.sink                 pts,
  ptl_out_if.source              res
);
  import ptl_pkg::*;

  localparam logic signed [NRW-1:0] OUT_MAX = {{(NRW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [NRW-1:0] OUT_MIN = ~OUT_MAX;

  function automatic logic [OW-1:0] sat_out(input logic signed [NRW-1:0] x);
    logic signed [NRW-1:0] y;
    y = x;
    if (x > OUT_MAX) y = OUT_MAX;
    if (x < OUT_MIN) y = OUT_MIN;
    return y[OW-1:0];
  endfunction

  logic signed [CW-1:0] cfg_s [3];
  logic signed [CW-1:0] cfg_e [3];

  logic en;
  logic a_load;

  logic                 vld_a;
  logic signed [DW-1:0] d_a [3];
  logic signed [DW-1:0] v_a [3];

  logic                 vld_b;
  logic signed [PW-1:0] dv_b [3];
  logic signed [PW-1:0] dd_b [3];
  logic signed [PW-1:0] vv_b [3];
  logic signed [DW-1:0] d_b [3];
  logic signed [DW-1:0] v_b [3];

  logic                 vld_c;
  logic signed [SW-1:0] dot_c;
  logic [SW-1:0]        dd_c;
  logic [SW-1:0]        vv_c;
  logic signed [DW-1:0] d_c [3];
  logic signed [DW-1:0] v_c [3];

  logic [MW-1:0]        dmag;
  logic [CW-1:0]        dabs [3];

  logic                 vld_d;
  logic [LOW+CW-1:0]    pl_d [3];
  logic [HIW+CW-1:0]    ph_d [3];
  logic                 dneg_d;
  logic [2:0]           dsgn_d;
  logic [SW-1:0]        dd_d;
  logic [SW-1:0]        vv_d;
  logic signed [DW-1:0] v_d [3];
  logic                 dot_pos_d;
  logic                 degen_d;

  logic  div_vld [QW+1];
  div_t  div_bus [QW+1];

  div_t                 dq;
  logic [QW-1:0]        qm [3];
  logic signed [QSW-1:0] q [3];

  logic                 vld_f;
  logic signed [RW-1:0] r_f [3];
  logic [2:0][OW-1:0]   near_f;
  logic [SW-1:0]        vv_f;
  logic                 dot_pos_f;
  logic                 degen_f;

  logic                 vld_g;
  logic [2*RW-1:0]      sq_g [3];
  logic [2:0][OW-1:0]   near_g;
  logic [SW-1:0]        vv_g;
  logic                 dot_pos_g;
  logic                 degen_g;

  logic  sq_vld [SQW+1];
  sqrt_t sq_bus [SQW+1];

  sqrt_t         sq_last;
  logic [LW-1:0] perp_sat;
  logic [LW-1:0] len_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cfg_s[i] <= '0;
        cfg_e[i] <= '0;
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_START_X: cfg_s[0] <= wr_data;
        REG_START_Y: cfg_s[1] <= wr_data;
        REG_START_Z: cfg_s[2] <= wr_data;
        REG_END_X:   cfg_e[0] <= wr_data;
        REG_END_Y:   cfg_e[1] <= wr_data;
        REG_END_Z:   cfg_e[2] <= wr_data;
        default: ;
      endcase
    end
  end

  assign en = !res.valid || res.ready;
  assign a_load = en || !vld_a;
  assign pts.ready = a_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
      div_vld[0] <= 1'b0;
      vld_f <= 1'b0;
      vld_g <= 1'b0;
      sq_vld[0] <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (a_load) begin
        vld_a <= pts.valid;
      end
      if (en) begin
        vld_b <= vld_a;
        vld_c <= vld_b;
        vld_d <= vld_c;
        div_vld[0] <= vld_d;
        vld_f <= div_vld[QW];
        vld_g <= vld_f;
        sq_vld[0] <= vld_g;
        res.valid <= sq_vld[SQW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      v_a[0] <= DW'(pts.point_x) - DW'(cfg_s[0]);
      v_a[1] <= DW'(pts.point_y) - DW'(cfg_s[1]);
      v_a[2] <= DW'(pts.point_z) - DW'(cfg_s[2]);
      for (int i = 0; i < 3; i++) begin
        d_a[i] <= DW'(cfg_e[i]) - DW'(cfg_s[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_b[i] <= PW'(d_a[i]) * PW'(v_a[i]);
        dd_b[i] <= PW'(d_a[i]) * PW'(d_a[i]);
        vv_b[i] <= PW'(v_a[i]) * PW'(v_a[i]);
        d_b[i]  <= d_a[i];
        v_b[i]  <= v_a[i];
      end
      dot_c <= SW'(dv_b[0]) + SW'(dv_b[1]) + SW'(dv_b[2]);
      dd_c  <= SW'(dd_b[0]) + SW'(dd_b[1]) + SW'(dd_b[2]);
      vv_c  <= SW'(vv_b[0]) + SW'(vv_b[1]) + SW'(vv_b[2]);
      for (int i = 0; i < 3; i++) begin
        d_c[i] <= d_b[i];
        v_c[i] <= v_b[i];
      end
    end
  end

  always_comb begin
    dmag = dot_c[SW-1] ? MW'(-dot_c) : MW'(dot_c);
    for (int i = 0; i < 3; i++) begin
      dabs[i] = d_c[i][DW-1] ? CW'(-d_c[i]) : CW'(d_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl_d[i]   <= (LOW+CW)'(dmag[LOW-1:0]) * (LOW+CW)'(dabs[i]);
        ph_d[i]   <= (HIW+CW)'(dmag[MW-1:LOW]) * (HIW+CW)'(dabs[i]);
        dsgn_d[i] <= d_c[i][DW-1];
        v_d[i]    <= v_c[i];
      end
      dneg_d    <= dot_c[SW-1];
      dd_d      <= dd_c;
      vv_d      <= vv_c;
      dot_pos_d <= !dot_c[SW-1] && (dot_c != '0);
      degen_d   <= (dd_c == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        div_bus[0].rem[i] <= NW'(pl_d[i]) + (NW'(ph_d[i]) << LOW);
        div_bus[0].quo[i] <= '0;
        div_bus[0].v[i]   <= v_d[i];
      end
      div_bus[0].dd      <= dd_d;
      div_bus[0].dneg    <= dneg_d;
      div_bus[0].dsgn    <= dsgn_d;
      div_bus[0].vv      <= vv_d;
      div_bus[0].dot_pos <= dot_pos_d;
      div_bus[0].degen   <= degen_d;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    ptl_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .bit_pos (QIW'(QW - 1 - j)),
      .vld_in  (div_vld[j]),
      .din     (div_bus[j]),
      .vld_out (div_vld[j+1]),
      .dout    (div_bus[j+1])
    );
  end

  always_comb begin
    dq = div_bus[QW];
    for (int i = 0; i < 3; i++) begin
      qm[i] = dq.degen ? '0 : dq.quo[i];
      q[i] = (dq.dneg != dq.dsgn[i]) ? -$signed({1'b0, qm[i]}) : $signed({1'b0, qm[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r_f[i]    <= RW'($signed(dq.v[i])) - RW'(q[i]);
        near_f[i] <= sat_out(NRW'(cfg_s[i]) + NRW'(q[i]));
      end
      vv_f      <= dq.vv;
      dot_pos_f <= dq.dot_pos;
      degen_f   <= dq.degen;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_g[i] <= (2*RW)'((2*RW)'(r_f[i]) * (2*RW)'(r_f[i]));
      end
      near_g    <= near_f;
      vv_g      <= vv_f;
      dot_pos_g <= dot_pos_f;
      degen_g   <= degen_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_bus[0].rrem    <= RRW'(sq_g[0]) + RRW'(sq_g[1]) + RRW'(sq_g[2]);
      sq_bus[0].vrem    <= RRW'(vv_g);
      sq_bus[0].rroot   <= '0;
      sq_bus[0].vroot   <= '0;
      sq_bus[0].nearest <= near_g;
      sq_bus[0].dot_pos <= dot_pos_g;
      sq_bus[0].degen   <= degen_g;
    end
  end

  for (genvar j = 0; j < SQW; j++) begin : g_sqrt
    ptl_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .bit_pos (SIW'(SQW - 1 - j)),
      .vld_in  (sq_vld[j]),
      .din     (sq_bus[j]),
      .vld_out (sq_vld[j+1]),
      .dout    (sq_bus[j+1])
    );
  end

  always_comb begin
    sq_last = sq_bus[SQW];
    perp_sat = (|sq_last.rroot[SQW-1:LW]) ? '1 : sq_last.rroot[LW-1:0];
    len_sat  = (|sq_last.vroot[SQW-1:LW]) ? '1 : sq_last.vroot[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.nearest_x     <= sq_last.nearest[0];
      res.nearest_y     <= sq_last.nearest[1];
      res.nearest_z     <= sq_last.nearest[2];
      res.perp_distance <= perp_sat;
      res.signed_length <= sq_last.dot_pos ? OW'({1'b0, len_sat}) : OW'(-{1'b0, len_sat});
      res.degenerate    <= sq_last.degen;
    end
  end

`ifndef SYNTH
  a_degen_nearest: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.degenerate |-> res.nearest_x == OW'(cfg_s[0]))
    else $error("degenerate line must project onto the first endpoint");

  a_degen_side: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.degenerate |-> res.signed_length[OW-1] || res.signed_length == '0)
    else $error("degenerate line must give a non-positive signed length");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    res.ready |-> pts.ready)
    else $error("input stalled while the output side is ready");
`endif

endmodule

// File: tb/point_to_line_distance_core_test.sv
module point_to_line_distance_core_test;
  import ptl_pkg::*;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
  } point_t;

  typedef struct {
    logic signed [OW-1:0] nx, ny, nz;
    logic [LW-1:0]        perp;
    logic signed [OW-1:0] slen;
    logic                 degen;
  } projection_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [IDXW-1:0] wr_index = '0;
  logic [CW-1:0] wr_data = '0;

  ptl_in_if pts();
  ptl_out_if res();

  point_to_line_distance_core dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .pts(pts.sink), .res(res.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [CW-1:0] line_reg [6];
  point_t pending_points [$];
  projection_t expected_projections [$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int degenerate_seen = 0;
  int idle_cycles = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit in_taken = 1'b0;

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned isqrt(logic [127:0] n);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= n) root = cand;
    end
    return root;
  endfunction

  function automatic logic signed [OW-1:0] clamp_out(logic signed [127:0] val);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (OW - 1)) - 1;
    lo = -hi - 1;
    if (val > hi) return hi[OW-1:0];
    if (val < lo) return lo[OW-1:0];
    return val[OW-1:0];
  endfunction

  function automatic projection_t project_point(point_t p);
    projection_t o;
    logic signed [127:0] s [3];
    logic signed [127:0] d [3];
    logic signed [127:0] v [3];
    logic signed [127:0] q [3];
    logic signed [127:0] dot, dd, vv, rr, r, num;
    logic [127:0] perp, len, lmax;
    s[0] = 128'(line_reg[0]); s[1] = 128'(line_reg[1]); s[2] = 128'(line_reg[2]);
    v[0] = 128'(p.x); v[1] = 128'(p.y); v[2] = 128'(p.z);
    dot = '0; dd = '0; vv = '0; rr = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 128'(line_reg[i + 3]);
      d[i] = d[i] - s[i];
      v[i] = v[i] - s[i];
      dot += d[i] * v[i];
      dd += d[i] * d[i];
      vv += v[i] * v[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (dd == 0) begin
        q[i] = '0;
      end else begin
        num = d[i] * dot;
        q[i] = num / dd;
      end
      r = v[i] - q[i];
      rr += r * r;
    end
    o.nx = clamp_out(s[0] + q[0]);
    o.ny = clamp_out(s[1] + q[1]);
    o.nz = clamp_out(s[2] + q[2]);
    perp = 128'(isqrt(rr));
    lmax = (128'd1 << LW) - 1;
    o.perp = (perp > lmax) ? lmax[LW-1:0] : perp[LW-1:0];
    len = 128'(isqrt(vv));
    lmax = (128'd1 << (OW - 1)) - 1;
    if (len > lmax) len = lmax;
    o.slen = (dot > 0) ? clamp_out($signed(len)) : clamp_out(-$signed(len));
    o.degen = (dd == 0);
    return o;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      pts.valid <= 1'b0;
      pts.point_x <= '0;
      pts.point_y <= '0;
      pts.point_z <= '0;
    end else if (in_taken) begin
      pts.valid <= 1'b0;
      send_gap = gap_length();
      if (send_gap == 0 && pending_points.size() > 0) begin
        pts.valid <= 1'b1;
        pts.point_x <= pending_points[0].x;
        pts.point_y <= pending_points[0].y;
        pts.point_z <= pending_points[0].z;
        void'(pending_points.pop_front());
      end
    end else if (!pts.valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_points.size() > 0) begin
        pts.valid <= 1'b1;
        pts.point_x <= pending_points[0].x;
        pts.point_y <= pending_points[0].y;
        pts.point_z <= pending_points[0].z;
        void'(pending_points.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    in_taken = !rst && pts.valid && pts.ready;
    if (in_taken) begin
      point_t p;
      p.x = pts.point_x; p.y = pts.point_y; p.z = pts.point_z;
      expected_projections.push_back(project_point(p));
      sent++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count--;
      res.ready <= 1'b0;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_count = 500;
      res.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      recv_gap = gap_length();
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      projection_t e;
      received++;
      if (expected_projections.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
      end else begin
        e = expected_projections.pop_front();
        if (e.degen) degenerate_seen++;
        if (res.nearest_x !== e.nx)
          $display("%0t: nearest_x expected %0d actual %0d", $time, e.nx, res.nearest_x);
        if (res.nearest_y !== e.ny)
          $display("%0t: nearest_y expected %0d actual %0d", $time, e.ny, res.nearest_y);
        if (res.nearest_z !== e.nz)
          $display("%0t: nearest_z expected %0d actual %0d", $time, e.nz, res.nearest_z);
        if (res.perp_distance !== e.perp)
          $display("%0t: perp_distance expected %0d actual %0d", $time, e.perp,
                   res.perp_distance);
        if (res.signed_length !== e.slen)
          $display("%0t: signed_length expected %0d actual %0d", $time, e.slen,
                   res.signed_length);
        if (res.degenerate !== e.degen)
          $display("%0t: degenerate expected %0b actual %0b", $time, e.degen,
                   res.degenerate);
        if (res.nearest_x !== e.nx || res.nearest_y !== e.ny || res.nearest_z !== e.nz ||
            res.perp_distance !== e.perp || res.signed_length !== e.slen ||
            res.degenerate !== e.degen)
          errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pts.valid && pts.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("FAIL point_to_line_distance_core");
        $finish;
      end
    end
  end

  task automatic write_line(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                            logic signed [CW-1:0] sz, logic signed [CW-1:0] ex,
                            logic signed [CW-1:0] ey, logic signed [CW-1:0] ez);
    logic signed [CW-1:0] vals [6];
    reg_idx_t idx;
    vals = '{sx, sy, sz, ex, ey, ez};
    for (int i = 0; i < 6; i++) begin
      idx = reg_idx_t'(i);
      @(negedge clk);
      wr_en <= 1'b1;
      wr_index <= idx;
      wr_data <= vals[i];
      line_reg[i] = vals[i];
    end
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_points.size() == 0);
    @(posedge clk);
    wait (!pts.valid && expected_projections.size() == 0);
    repeat (70) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int range_bits);
    logic signed [CW-1:0] c;
    c = CW'($urandom());
    if (range_bits < CW) c = c >>> (CW - range_bits);
    return c;
  endfunction

  task automatic queue_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    pending_points.push_back(p);
  endtask

  localparam logic signed [CW-1:0] CMAX = CW'((1 <<< (CW - 1)) - 1);
  localparam logic signed [CW-1:0] CMIN = CW'(-(1 <<< (CW - 1)));

  initial begin
    int bits;
    for (int i = 0; i < 6; i++) line_reg[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset line is degenerate: both endpoints at the origin.
    queue_point(0, 0, 0);
    queue_point(CMAX, CMIN, 256);
    wait_drained();

    write_line(0, 0, 0, 256, 0, 0);
    queue_point(0, 0, 0);
    queue_point(0, 512, 0);
    queue_point(-256, 300, -7);
    queue_point(1000, -1000, 77);
    queue_point(CMAX, CMAX, CMAX);
    queue_point(CMIN, CMIN, CMIN);
    wait_drained();

    write_line(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    queue_point(CMAX, CMIN, CMAX);
    queue_point(CMIN, CMAX, CMIN);
    queue_point(CMAX, CMAX, CMAX);
    queue_point(CMIN, CMIN, CMIN);
    queue_point(0, 0, 0);
    queue_point(-1, -1, -1);
    wait_drained();

    write_line(CMAX, CMIN, 0, CMIN, CMAX, 0);
    queue_point(CMIN, CMIN, CMAX);
    queue_point(CMAX, CMAX, CMIN);
    queue_point(0, 0, CMIN);
    wait_drained();

    write_line(12345, -6789, 100, 12345, -6789, 100);
    queue_point(12345, -6789, 100);
    queue_point(CMIN, CMAX, CMIN);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      bits = (phase % 3 == 0) ? CW : $urandom_range(6, CW);
      if (phase == 5)
        write_line(rand_coord(bits), 0, 0, rand_coord(bits), 0, 0);
      else if (phase == 6) begin
        logic signed [CW-1:0] a, b, c;
        a = rand_coord(bits); b = rand_coord(bits); c = rand_coord(bits);
        write_line(a, b, c, a, b, c);
      end else
        write_line(rand_coord(bits), rand_coord(bits), rand_coord(bits),
                   rand_coord(bits), rand_coord(bits), rand_coord(bits));
      if (phase == 2) hold_requests++;
      for (int k = 0; k < ((phase == 2) ? 120 : 40); k++) begin
        if ($urandom_range(0, 9) == 0)
          queue_point(line_reg[$urandom_range(0, 1) * 3], line_reg[1], line_reg[2]);
        else
          queue_point(rand_coord(bits), rand_coord(bits), rand_coord(bits));
      end
      wait_drained();
    end

    $display("Sent %0d points and checked %0d results over 13 line settings.", sent,
             received);
    $display("Degenerate lines covered %0d results; %0d errors.", degenerate_seen, errors);
    if (errors == 0)
      $display("PASS point_to_line_distance_core");
    else
      $display("FAIL point_to_line_distance_core");
    $finish;
  end

endmodule

// File: files.f
design/ptl_pkg.sv
design/ptl_if.sv
design/ptl_div_cell.sv
design/ptl_sqrt_cell.sv
design/point_to_line_distance_core.sv
tb/point_to_line_distance_core_test.sv
